// File: src/rapg_pkg.sv
package rapg_pkg;

   // CORDIC sizing
   localparam int CORDIC_ITERS = 16;
   localparam int ITER_W       = 4;

   // Q2.30 start value that cancels the CORDIC gain
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // rounding half for a right shift by 15
   localparam int Q15_HALF = 16384;

   // armor count that selects the second radius and height
   localparam int PAIR_COUNT = 4;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic init;
      logic rotate;
      logic scale;
      logic mul_x;
      logic mul_y;
      logic emit;
   } rapg_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic empty;
      logic rot_done;
      logic last;
   } rapg_status_type;

   // atan(2^-k) with a full turn equal to 2^32
   function automatic logic [31:0] atan_turn32(input logic [ITER_W-1:0] k);
      logic [31:0] a;
      case (k)
         4'd0:    a = 32'd536870912;
         4'd1:    a = 32'd316933406;
         4'd2:    a = 32'd167458907;
         4'd3:    a = 32'd85004756;
         4'd4:    a = 32'd42667331;
         4'd5:    a = 32'd21354465;
         4'd6:    a = 32'd10679838;
         4'd7:    a = 32'd5340245;
         4'd8:    a = 32'd2670163;
         4'd9:    a = 32'd1335087;
         4'd10:   a = 32'd667544;
         4'd11:   a = 32'd333772;
         4'd12:   a = 32'd166886;
         4'd13:   a = 32'd83443;
         4'd14:   a = 32'd41722;
         default: a = 32'd20861;
      endcase
      return a;
   endfunction

endpackage

// File: src/ring_armor_pose_generator.sv
// Ring armor pose generator. A request (start high while busy is low) gives a
// target's center, heading, two radii, a second height and an armor count; the
// block answers with one result per armor, strobed on rsp_valid for exactly one
// cycle, in ring order, with rsp_last_armor on the final one. There is no way to
// hold results off, so the receiver must take each strobe as it comes. Each armor
// runs the 16 iterations of the shared CORDIC plus setup, scaling, two passes
// through the single multiplier and the emit step; busy drops in the cycle the
// last result is strobed (after setup alone when the count is zero), so the next
// request can be taken at the end of that same cycle.
module ring_armor_pose_generator #(
   parameter int MAX_ARMORS = 4,
   parameter int ANGLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic signed [15:0] req_heading,
   input  logic [19:0]        req_radius_first,
   input  logic [19:0]        req_radius_second,
   input  logic signed [31:0] req_height_second,
   input  logic [2:0]         req_armor_count,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_armor_x,
   output logic signed [31:0] rsp_armor_y,
   output logic signed [31:0] rsp_armor_z,
   output logic signed [15:0] rsp_armor_angle,
   output logic [1:0]         rsp_armor_index,
   output logic               rsp_last_armor
);
   import rapg_pkg::*;

   rapg_cmd_type    cmd;
   rapg_status_type status;

   rapg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   rapg_datapath #(
      .MAX_ARMORS (MAX_ARMORS),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_center_z      (req_center_z),
      .req_heading       (req_heading),
      .req_radius_first  (req_radius_first),
      .req_radius_second (req_radius_second),
      .req_height_second (req_height_second),
      .req_armor_count   (req_armor_count),
      .rsp_valid         (rsp_valid),
      .rsp_armor_x       (rsp_armor_x),
      .rsp_armor_y       (rsp_armor_y),
      .rsp_armor_z       (rsp_armor_z),
      .rsp_armor_angle   (rsp_armor_angle),
      .rsp_armor_index   (rsp_armor_index),
      .rsp_last_armor    (rsp_last_armor)
   );

endmodule

// File: src/rapg_cordic.sv
module rapg_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               init,
   input  logic               step,
   input  logic [31:0]        phase,
   output logic               done,
   output logic signed [15:0] cos_q15,
   output logic signed [15:0] sin_q15
);
   import rapg_pkg::*;

   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic               flip_ff, flip_in;
   logic               flip_now;
   logic [31:0]        t_fold;
   logic signed [33:0] x_sh, y_sh;
   logic signed [32:0] atan_k;
   logic signed [15:0] cos_abs, sin_abs;

   // round Q2.30 to Q1.15 and clamp to +-32767
   function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
      logic signed [33:0] s;
      logic signed [18:0] r;
      s = v + 34'(Q15_HALF);
      r = 19'(s >>> 15);
      if (r > 19'sd32767) r = 19'sd32767;
      if (r < -19'sd32767) r = -19'sd32767;
      return 16'(r);
   endfunction

   // fold the second and third quadrants onto the first and fourth
   always_comb begin
      flip_now = phase[31] ^ phase[30];
      t_fold   = {phase[31] ^ flip_now, phase[30:0]};
      x_sh     = x_ff >>> iter_ff;
      y_sh     = y_ff >>> iter_ff;
      atan_k   = 33'(atan_turn32(iter_ff));
   end

   // one micro-rotation per cycle while step is high
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      iter_in = iter_ff;
      if (init) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = 33'($signed(t_fold));
         flip_in = flip_now;
         iter_in = '0;
      end else if (step) begin
         if (!z_ff[32]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_k;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_k;
         end
         iter_in = iter_ff + ITER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
      end else begin
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   // results, negated back for folded angles
   always_comb begin
      done    = (iter_ff == ITER_W'(CORDIC_ITERS - 1));
      cos_abs = to_q15(x_ff);
      sin_abs = to_q15(y_ff);
      cos_q15 = flip_ff ? -cos_abs : cos_abs;
      sin_q15 = flip_ff ? -sin_abs : sin_abs;
   end

endmodule

// File: src/rapg_datapath.sv
module rapg_datapath #(
   parameter int MAX_ARMORS = 4,
   parameter int ANGLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rapg_pkg::rapg_cmd_type    cmd,
   output rapg_pkg::rapg_status_type status,
   input  logic signed [31:0]        req_center_x,
   input  logic signed [31:0]        req_center_y,
   input  logic signed [31:0]        req_center_z,
   input  logic signed [15:0]        req_heading,
   input  logic [19:0]               req_radius_first,
   input  logic [19:0]               req_radius_second,
   input  logic signed [31:0]        req_height_second,
   input  logic [2:0]                req_armor_count,
   output logic                      rsp_valid,
   output logic signed [31:0]        rsp_armor_x,
   output logic signed [31:0]        rsp_armor_y,
   output logic signed [31:0]        rsp_armor_z,
   output logic signed [15:0]        rsp_armor_angle,
   output logic [1:0]                rsp_armor_index,
   output logic                      rsp_last_armor
);
   import rapg_pkg::*;

   localparam int CNT_W = $clog2(MAX_ARMORS + 1);
   localparam int IDX_W = $clog2(MAX_ARMORS);
   localparam int UP    = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
   localparam int DN    = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
   localparam int AW    = ANGLE_BITS + 16;

   // request registers
   logic signed [31:0] cx_ff, cy_ff, cz_ff, z1_ff;
   logic [15:0]        head_ff;
   logic [19:0]        r0_ff, r1_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff;

   // per-armor working registers
   logic [15:0]        angle_ff;
   logic signed [15:0] cos_ff, sin_ff;
   logic signed [36:0] prod_ff, prod_in;
   logic signed [31:0] ax_ff;

   // result registers
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [15:0]        rsp_angle_ff;
   logic [1:0]         rsp_index_ff;
   logic               rsp_last_ff;

   logic [ANGLE_BITS-1:0] step_tab [MAX_ARMORS + 1][MAX_ARMORS];
   logic [ANGLE_BITS-1:0] hphase, phase;
   logic [AW-1:0]         head_wide, angle_wide;
   logic [31:0]           phase32;
   logic [15:0]           angle16;
   logic                  pair;
   logic [19:0]           r_sel;
   logic signed [15:0]    trig_sel;
   logic signed [36:0]    round_sum;
   logic signed [21:0]    offset;
   logic signed [31:0]    center_sel;
   logic signed [32:0]    diff;
   logic signed [31:0]    pos_sat;
   logic                  rot_done;
   logic signed [15:0]    cord_cos, cord_sin;

   // angular step of armor i among c armors, rounded half up
   for (genvar c = 0; c <= MAX_ARMORS; c++) begin : g_cnt
      for (genvar i = 0; i < MAX_ARMORS; i++) begin : g_idx
         if (c == 0) begin : g_zero
            assign step_tab[c][i] = '0;
         end else begin : g_val
            localparam int StepVal = (i * (1 << ANGLE_BITS) + c / 2) / c;
            assign step_tab[c][i] = ANGLE_BITS'(StepVal);
         end
      end
   end

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else r = v[31:0];
      return r;
   endfunction

   // count saturation at load
   always_comb begin
      if (32'(req_armor_count) > MAX_ARMORS) count_in = CNT_W'(MAX_ARMORS);
      else count_in = CNT_W'(req_armor_count);
   end

   // phase of the current armor
   always_comb begin
      head_wide  = (AW'(head_ff) << UP) >> DN;
      hphase     = head_wide[ANGLE_BITS-1:0];
      phase      = hphase + step_tab[count_ff][idx_ff];
      phase32    = 32'(phase) << (32 - ANGLE_BITS);
      angle_wide = (AW'(phase) >> UP) << DN;
      angle16    = angle_wide[15:0];
   end

   // second pair selection, shared multiplier and saturation
   always_comb begin
      pair       = (32'(count_ff) == PAIR_COUNT) &&
                   ((32'(idx_ff) == 1) || (32'(idx_ff) == 3));
      r_sel      = pair ? r1_ff : r0_ff;
      trig_sel   = cmd.mul_y ? sin_ff : cos_ff;
      prod_in    = 37'($signed({1'b0, r_sel})) * 37'(trig_sel);
      round_sum  = prod_ff + 37'(Q15_HALF);
      offset     = 22'(round_sum >>> 15);
      center_sel = cmd.emit ? cy_ff : cx_ff;
      diff       = 33'(center_sel) - 33'(offset);
      pos_sat    = sat32(diff);
   end

   rapg_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .init    (cmd.init),
      .step    (cmd.rotate),
      .phase   (phase32),
      .done    (rot_done),
      .cos_q15 (cord_cos),
      .sin_q15 (cord_sin)
   );

   always_comb begin
      status.empty    = (count_ff == '0);
      status.rot_done = rot_done;
      status.last     = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff    <= req_center_x;
         cy_ff    <= req_center_y;
         cz_ff    <= req_center_z;
         head_ff  <= req_heading;
         r0_ff    <= req_radius_first;
         r1_ff    <= req_radius_second;
         z1_ff    <= req_height_second;
         count_ff <= count_in;
         idx_ff   <= '0;
      end
      if (cmd.init) begin
         angle_ff <= angle16;
      end
      if (cmd.scale) begin
         cos_ff <= cord_cos;
         sin_ff <= cord_sin;
      end
      if (cmd.mul_x || cmd.mul_y) begin
         prod_ff <= prod_in;
      end
      if (cmd.mul_y) begin
         ax_ff <= pos_sat;
      end
      if (cmd.emit) begin
         rsp_x_ff     <= ax_ff;
         rsp_y_ff     <= pos_sat;
         rsp_z_ff     <= pair ? z1_ff : cz_ff;
         rsp_angle_ff <= angle_ff;
         rsp_index_ff <= 2'(idx_ff);
         rsp_last_ff  <= status.last;
         idx_ff       <= idx_ff + IDX_W'(1);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_armor_x     = rsp_x_ff;
   assign rsp_armor_y     = rsp_y_ff;
   assign rsp_armor_z     = rsp_z_ff;
   assign rsp_armor_angle = rsp_angle_ff;
   assign rsp_armor_index = rsp_index_ff;
   assign rsp_last_armor  = rsp_last_ff;

   // each armor passes through init, rotation, scale and multiply states between emits, so strobes never touch
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

endmodule

// File: src/rapg_ctrl.sv
module rapg_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  rapg_pkg::rapg_status_type status,
   output logic                      busy,
   output rapg_pkg::rapg_cmd_type    cmd
);
   import rapg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROTATE,
      ST_SCALE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // sequencing: init, 16 rotations, scale, two multiplies, emit per armor
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = status.empty ? ST_IDLE : ST_ROTATE;
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            if (status.rot_done) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_MUL_X;
         end
         ST_MUL_X: begin
            cmd.mul_x = 1'b1;
            state_in  = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.mul_y = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = status.last ? ST_IDLE : ST_INIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

   a_rotate_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE) && !status.rot_done |=> (state_ff == ST_ROTATE))
      else $error("rotation left before the last iteration");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && status.last |=> !busy_ff)
      else $error("still busy after the final armor");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(start))
      else $error("busy rose without a request");

endmodule
